FILE: sv/radio_frame_checker_reassembler_unit_macros.svh
// Assertion macros for the radio frame checker and reassembler.
`ifndef RADIO_FRAME_CHECKER_REASSEMBLER_UNIT_MACROS_SVH
`define RADIO_FRAME_CHECKER_REASSEMBLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk and masked during reset.
`define RFCR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: assertion failed");

// Next-cycle implication, sampled on clk and masked during reset.
`define RFCR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: assertion failed");

`else

`define RFCR_ASSERT_IMPL(name, ante, cons)
`define RFCR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: sv/rfcr_pkg.sv
// Shared constants, codes and types of the radio frame checker and reassembler.
package rfcr_pkg;

	localparam int FRAME_BYTES   = 19;
	localparam int PAYLOAD_BYTES = 14;
	localparam int HEADER_BYTES  = 1;
	localparam int MESSAGE_BYTES = 256;
	localparam int CHECK_BYTES   = 4;

	// Bytes between the header and the trailing check word.
	localparam int BODY_BYTES     = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;
	localparam int BODY_BITS      = BODY_BYTES * 8;
	localparam int STORE_BYTES    = HEADER_BYTES + BODY_BYTES;
	localparam int LAST_LEN_LIMIT = FRAME_BYTES - HEADER_BYTES - CHECK_BYTES;

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int MSG_W = 8;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);
	localparam logic [MSG_W-1:0] MSG_LAST = MSG_W'(MESSAGE_BYTES - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_CONTROL   = 2'd0,
		ST_COMPLETE  = 2'd1,
		ST_CONTINUE  = 2'd2,
		ST_CHECK_ERR = 2'd3
	} frame_status_t;

	// One received frame as handed from the front to the back.
	typedef struct packed {
		logic [7:0]           header;
		logic [BODY_BITS-1:0] body;
		logic                 chk_ok;
	} frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: sv/rfcr_in_if.sv
// Byte input channel: valid, ready and one received byte.
interface rfcr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

FILE: sv/rfcr_out_if.sv
// Result output channel: valid, ready and one result item.
interface rfcr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  header_byte;
	logic [15:0] speed;
	logic [31:0] yaw_bits;
	logic [31:0] pitch_bits;
	logic [31:0] roll_bits;
	logic [7:0]  cmd_byte;
	logic [7:0]  cmd_index;
	logic [7:0]  message_length;
	logic        last;

	modport source (
		output valid, output status, output header_byte, output speed,
		output yaw_bits, output pitch_bits, output roll_bits, output cmd_byte,
		output cmd_index, output message_length, output last, input ready
	);
	modport sink (
		input valid, input status, input header_byte, input speed,
		input yaw_bits, input pitch_bits, input roll_bits, input cmd_byte,
		input cmd_index, input message_length, input last, output ready
	);
endinterface

FILE: sv/rfcr_front.sv
// Front end: gathers frame bytes, runs the XOR check and queues whole frames.
module rfcr_front (
	input  logic             clk,
	input  logic             arst_n,
	rfcr_in_if.sink          rx_ch,
	input  rfcr_pkg::q_stat_t q_stat,
	output logic             push,
	output rfcr_pkg::frame_t push_frame
);
	import rfcr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_cur;
	logic [POS_W-1:0] pos_p1;
	logic [7:0]       store_q [STORE_BYTES];
	logic [31:0]      acc_q;
	logic [31:0]      acc_cur;
	logic [31:0]      contrib;
	logic [1:0]       lane;
	logic             accept;
	logic             at_end;

	// Stall only the closing byte of a frame, and only while the queue is full.
	assign rx_ch.ready = !(q_stat.full && (pos_q == POS_LAST));
	assign accept      = rx_ch.valid && rx_ch.ready;

	assign pos_cur = rx_ch.frame_start ? '0 : pos_q;
	assign pos_p1  = pos_cur + POS_W'(1);
	assign at_end  = (pos_cur == POS_LAST);

	// Byte lane of the running check word; the check bytes fold in too, so
	// a good frame leaves the accumulator at zero.
	always_comb begin
		if (pos_cur == POS_W'(1)) begin
			lane = 2'd1;
		end else if (pos_cur == POS_W'(0) || pos_cur == POS_W'(2)) begin
			lane = 2'd0;
		end else begin
			lane = ~pos_p1[1:0];
		end
		contrib = 32'(rx_ch.rx_byte) << {lane, 3'b000};
		acc_cur = ((pos_cur == '0) ? 32'd0 : acc_q) ^ contrib;
	end

	// Frame handed to the queue together with the closing byte.
	always_comb begin
		push              = accept && at_end;
		push_frame.header = store_q[0];
		push_frame.chk_ok = (acc_cur == 32'd0);
		for (int i = 0; i < BODY_BYTES; i++) begin
			push_frame.body[(BODY_BYTES-1-i)*8 +: 8] = store_q[HEADER_BYTES+i];
		end
	end

	// Byte position and check accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
		end else if (accept) begin
			pos_q <= at_end ? '0 : pos_p1;
			acc_q <= acc_cur;
		end
	end

	// Header and body bytes of the frame being gathered.
	always_ff @(posedge clk) begin
		for (int i = 0; i < STORE_BYTES; i++) begin
			if (accept && pos_cur == POS_W'(i)) begin
				store_q[i] <= rx_ch.rx_byte;
			end
		end
	end

endmodule

FILE: sv/rfcr_frame_queue.sv
// Short frame queue between the front end and the result sequencer.
module rfcr_frame_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rfcr_pkg::frame_t  push_frame,
	input  logic              pop,
	output rfcr_pkg::frame_t  head,
	output rfcr_pkg::q_stat_t stat
);
	import rfcr_pkg::*;

	frame_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

FILE: sv/rfcr_back.sv
// Back end: turns each queued frame into its result transfers.
module rfcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rfcr_pkg::frame_t  head,
	input  rfcr_pkg::q_stat_t q_stat,
	output logic              pop,
	rfcr_out_if.source        res_ch
);
	import rfcr_pkg::*;

	frame_t           cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MSG_W-1:0] msg_pos_q;
	logic [7:0]       exp_len_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       header_q;
	logic [15:0]      speed_q;
	logic [31:0]      yaw_q;
	logic [31:0]      pitch_q;
	logic [31:0]      roll_q;
	logic [7:0]       cmd_byte_q;
	logic [7:0]       cmd_index_q;
	logic [7:0]       msg_len_q;
	logic             last_q;

	logic             step;
	logic             is_ctrl;
	logic             is_data;
	logic             done_msg;
	logic             final_res;
	logic [7:0]       exp_eff;
	logic [MSG_W-1:0] msg_pos_inc;
	frame_status_t    status_n;

	assign pop  = !cur_valid_q && !q_stat.empty;
	assign step = cur_valid_q && (!out_valid_q || res_ch.ready);

	// Classify the frame in hand and form the next result.
	always_comb begin
		is_ctrl     = cur_q.chk_ok && (cur_q.header == 8'd0);
		is_data     = cur_q.chk_ok && (cur_q.header != 8'd0);
		done_msg    = (cur_q.header <= 8'(LAST_LEN_LIMIT));
		final_res   = !is_data || (cnt_q == CNT_LAST);
		exp_eff     = (exp_len_q == 8'd0) ? cur_q.header : exp_len_q;
		msg_pos_inc = (msg_pos_q == MSG_LAST) ? '0 : msg_pos_q + MSG_W'(1);
		if (!cur_q.chk_ok) begin
			status_n = ST_CHECK_ERR;
		end else if (is_ctrl) begin
			status_n = ST_CONTROL;
		end else if (done_msg) begin
			status_n = ST_COMPLETE;
		end else begin
			status_n = ST_CONTINUE;
		end
	end

	// Sequencer and message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cnt_q       <= '0;
			msg_pos_q   <= '0;
			exp_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				cnt_q       <= '0;
			end else if (step) begin
				if (final_res) begin
					cur_valid_q <= 1'b0;
				end
				cnt_q <= cnt_q + CNT_W'(1);
				if (!cur_q.chk_ok) begin
					msg_pos_q <= '0;
				end else if (is_data) begin
					if (final_res && done_msg) begin
						msg_pos_q <= '0;
						exp_len_q <= '0;
					end else begin
						msg_pos_q <= msg_pos_inc;
						exp_len_q <= exp_eff;
					end
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Frame in hand and output register; the body shifts one payload byte per result.
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end else if (step) begin
			cur_q.body <= cur_q.body << 8;
		end
		if (step) begin
			status_q    <= status_n;
			header_q    <= cur_q.header;
			speed_q     <= is_ctrl ? cur_q.body[BODY_BITS-1 -: 16] : 16'd0;
			yaw_q       <= is_ctrl ? cur_q.body[BODY_BITS-17 -: 32] : 32'd0;
			pitch_q     <= is_ctrl ? cur_q.body[BODY_BITS-49 -: 32] : 32'd0;
			roll_q      <= is_ctrl ? cur_q.body[BODY_BITS-81 -: 32] : 32'd0;
			cmd_byte_q  <= is_data ? cur_q.body[BODY_BITS-1 -: 8] : 8'd0;
			cmd_index_q <= is_data ? 8'(msg_pos_q) : 8'd0;
			msg_len_q   <= (is_data && done_msg) ? exp_eff : 8'd0;
			last_q      <= final_res;
		end
	end

	assign res_ch.valid          = out_valid_q;
	assign res_ch.status         = status_q;
	assign res_ch.header_byte    = header_q;
	assign res_ch.speed          = speed_q;
	assign res_ch.yaw_bits       = yaw_q;
	assign res_ch.pitch_bits     = pitch_q;
	assign res_ch.roll_bits      = roll_q;
	assign res_ch.cmd_byte       = cmd_byte_q;
	assign res_ch.cmd_index      = cmd_index_q;
	assign res_ch.message_length = msg_len_q;
	assign res_ch.last           = last_q;

endmodule

FILE: sv/radio_frame_checker_reassembler_unit.sv
// A frame's first result is offered once it has passed the queue and the frame and output
// registers. Throughput: one byte per cycle while ready is high; a frame gives 1 result,
// or 14 for a data frame; at full output rate 19-byte frames never back up the queue.
// Input stalls only on a closing byte while both queue entries are taken.
// Reset (arst_n low, asynchronous) clears the frame position, queue, message
// position and expected length; frame byte storage is not reset.
`include "radio_frame_checker_reassembler_unit_macros.svh"

module radio_frame_checker_reassembler_unit (
	input logic        clk,
	input logic        arst_n,
	rfcr_in_if.sink    rx_ch,
	rfcr_out_if.source res_ch
);
	import rfcr_pkg::*;

	logic    push;
	logic    pop;
	frame_t  push_frame;
	frame_t  head;
	q_stat_t q_stat;

	// Byte gathering and checksum.
	rfcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_ch      (rx_ch),
		.q_stat     (q_stat),
		.push       (push),
		.push_frame (push_frame)
	);

	// Frame queue.
	rfcr_frame_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// Result sequencing.
	rfcr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res_ch (res_ch)
	);

	// A finished frame is never offered to a full queue.
	`RFCR_ASSERT_IMPL(a_no_push_when_full, push, !q_stat.full)
	// The input stalls only because the queue is full.
	`RFCR_ASSERT_IMPL(a_stall_means_full, !rx_ch.ready, q_stat.full)
	// A queued frame is still held in the cycle after it is pushed.
	`RFCR_ASSERT_NEXT(a_push_fills_queue, push, !q_stat.empty)
	// A checksum error is always a single, final result.
	`RFCR_ASSERT_IMPL(a_err_is_last, res_ch.valid && res_ch.status == ST_CHECK_ERR, res_ch.last)

endmodule

FILE: tb/radio_frame_checker_reassembler_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the radio frame checker and reassembler, with its own frame predictor.
module radio_frame_checker_reassembler_unit_tb;
	import rfcr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_WAIT     = 19;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} rx_item_t;

	typedef struct packed {
		frame_status_t status;
		logic [7:0]    header_byte;
		logic [15:0]   speed;
		logic [31:0]   yaw_bits;
		logic [31:0]   pitch_bits;
		logic [31:0]   roll_bits;
		logic [7:0]    cmd_byte;
		logic [7:0]    cmd_index;
		logic [7:0]    message_length;
		logic          last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	rfcr_in_if  rx_ch ();
	rfcr_out_if res_ch ();

	radio_frame_checker_reassembler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_ch(rx_ch),
		.res_ch(res_ch)
	);

	// Bytes still to send and results still owed by the block.
	rx_item_t tx_bytes[$];
	result_t  expected_results[$];

	// Predictor copy of the frame buffer and message tracking.
	logic [7:0] frame_copy [FRAME_BYTES];
	int         frame_pos;
	logic [7:0] msg_pos;
	logic [7:0] msg_len;

	int       errors = 0;
	int       cycles = 0;
	int       bytes_sent = 0;
	int       results_checked = 0;
	int       frames_seen [4] = '{0, 0, 0, 0};
	int       gap_left;
	int       stall_left;
	int       stall_draw;
	bit       tx_calm;
	bit       rx_calm;
	rx_item_t tx_item;
	result_t  got;
	result_t  want;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Big-endian 32-bit word of the predictor's frame copy.
	function automatic logic [31:0] word_at(input int at);
		return {frame_copy[at], frame_copy[at + 1], frame_copy[at + 2], frame_copy[at + 3]};
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf(
			"st=%0d hd=%h sp=%h yaw=%h pit=%h rol=%h cb=%h ci=%h ml=%h last=%b",
			r.status, r.header_byte, r.speed, r.yaw_bits, r.pitch_bits, r.roll_bits,
			r.cmd_byte, r.cmd_index, r.message_length, r.last);
	endfunction

	// Takes one transferred byte and queues the results its frame should produce.
	task automatic reassemble_byte(input logic [7:0] rx_byte, input logic frame_start);
		logic [7:0]  hdr;
		logic [15:0] spd;
		logic [31:0] sum;
		result_t     r;
		if (frame_start)
			frame_pos = 0;
		frame_copy[frame_pos] = rx_byte;
		if (frame_pos < FRAME_BYTES - 1) begin
			frame_pos++;
			return;
		end
		frame_pos = 0;
		hdr = frame_copy[0];
		spd = {frame_copy[1], frame_copy[2]};
		sum = {24'd0, hdr} ^ {16'd0, spd} ^ word_at(3) ^ word_at(7) ^ word_at(11);
		r = '0;
		r.header_byte = hdr;
		r.last = 1'b1;
		if (sum != word_at(15)) begin
			// A bad check word restarts the message index but keeps the length.
			r.status = ST_CHECK_ERR;
			msg_pos = '0;
			expected_results.push_back(r);
		end else if (hdr == 8'd0) begin
			r.status = ST_CONTROL;
			r.speed = spd;
			r.yaw_bits = word_at(3);
			r.pitch_bits = word_at(7);
			r.roll_bits = word_at(11);
			expected_results.push_back(r);
		end else begin
			// Data frame: the first header of a message fixes its length.
			if (msg_len == 8'd0)
				msg_len = hdr;
			r.status = (hdr <= LAST_LEN_LIMIT) ? ST_COMPLETE : ST_CONTINUE;
			r.message_length = (r.status == ST_COMPLETE) ? msg_len : 8'd0;
			for (int k = 0; k < PAYLOAD_BYTES; k++) begin
				r.cmd_byte = frame_copy[HEADER_BYTES + k];
				r.cmd_index = 8'((int'(msg_pos) + k) % MESSAGE_BYTES);
				r.last = (k == PAYLOAD_BYTES - 1);
				expected_results.push_back(r);
			end
			msg_pos = 8'((int'(msg_pos) + PAYLOAD_BYTES) % MESSAGE_BYTES);
			if (r.status == ST_COMPLETE) begin
				msg_pos = '0;
				msg_len = '0;
			end
		end
	endtask

	function automatic logic [BODY_BITS-1:0] rand_body();
		return {$urandom, $urandom, $urandom, 16'($urandom)};
	endfunction

	// Queues one whole frame with a matching check word, or a damaged one.
	task automatic queue_frame(input logic [7:0] hdr, input logic [BODY_BITS-1:0] body,
			input bit corrupt, input bit mark_start);
		logic [31:0] chk;
		logic [7:0]  bytes_out [FRAME_BYTES];
		rx_item_t    item;
		chk = {24'd0, hdr} ^ {16'd0, body[111:96]} ^ body[95:64] ^ body[63:32] ^ body[31:0];
		if (corrupt)
			chk ^= 32'd1 << $urandom_range(0, 31);
		bytes_out[0] = hdr;
		for (int k = 0; k < BODY_BYTES; k++)
			bytes_out[HEADER_BYTES + k] = body[BODY_BITS - 1 - 8 * k -: 8];
		for (int k = 0; k < CHECK_BYTES; k++)
			bytes_out[STORE_BYTES + k] = chk[31 - 8 * k -: 8];
		for (int k = 0; k < FRAME_BYTES; k++) begin
			item.rx_byte = bytes_out[k];
			item.frame_start = (k == 0) ? mark_start : 1'b0;
			tx_bytes.push_back(item);
		end
	endtask

	// Stray bytes, some of them flagged as a frame start.
	task automatic queue_noise(input int count);
		rx_item_t item;
		for (int i = 0; i < count; i++) begin
			item.rx_byte = 8'($urandom);
			item.frame_start = ($urandom_range(0, 3) == 0);
			tx_bytes.push_back(item);
		end
	endtask

	// Byte driver: one transfer per handshake, with a random gap before each byte.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= '0;
			rx_ch.frame_start <= 1'b0;
			gap_left <= 0;
			tx_calm <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				reassemble_byte(rx_ch.rx_byte, rx_ch.frame_start);
				bytes_sent++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (gap_left != 0) begin
					rx_ch.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (tx_bytes.size() != 0) begin
					tx_item = tx_bytes.pop_front();
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= tx_item.rx_byte;
					rx_ch.frame_start <= tx_item.frame_start;
					gap_left <= tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
					if ($urandom_range(0, 39) == 0)
						tx_calm <= !tx_calm;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each transfer and stalls ready at random between results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left <= 0;
			rx_calm <= 1'b0;
		end else if (res_ch.ready) begin
			if (res_ch.valid) begin
				got.status = frame_status_t'(res_ch.status);
				got.header_byte = res_ch.header_byte;
				got.speed = res_ch.speed;
				got.yaw_bits = res_ch.yaw_bits;
				got.pitch_bits = res_ch.pitch_bits;
				got.roll_bits = res_ch.roll_bits;
				got.cmd_byte = res_ch.cmd_byte;
				got.cmd_index = res_ch.cmd_index;
				got.message_length = res_ch.message_length;
				got.last = res_ch.last;
				results_checked++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %s", $time, describe(got));
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected %s, got %s", $time, describe(want), describe(got));
					end
				end
				if (got.last === 1'b1)
					frames_seen[got.status]++;
				stall_draw = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
				res_ch.ready <= (stall_draw == 0);
				stall_left <= stall_draw;
				if ($urandom_range(0, 39) == 0)
					rx_calm <= !rx_calm;
			end
		end else if (stall_left <= 1) begin
			res_ch.ready <= 1'b1;
			stall_left <= 0;
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	// Run watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		frame_pos = 0;
		msg_pos = '0;
		msg_len = '0;

		// A control frame with every payload bit set.
		queue_frame(8'd0, '1, 1'b0, 1'b1);
		// A message opened by the largest header and continued at the boundary header
		// by a frame that follows on without a start mark.
		queue_frame(8'd255, '1, 1'b0, 1'b1);
		queue_frame(8'd15, rand_body(), 1'b0, 1'b0);
		// A bad check word restarts the index, stray bytes follow, and the message
		// closes at the boundary header with the length of its first frame.
		queue_frame(8'h80, rand_body(), 1'b1, 1'b1);
		queue_noise(5);
		queue_frame(8'd14, rand_body(), 1'b0, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (tx_bytes.size() != 0 || rx_ch.valid === 1'b1 || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes under random gaps and stalls, and checked %0d results.",
			bytes_sent, results_checked);
		$display("Frames: %0d control, %0d closing, %0d continuing, %0d failed check.",
			frames_seen[ST_CONTROL], frames_seen[ST_COMPLETE], frames_seen[ST_CONTINUE],
			frames_seen[ST_CHECK_ERR]);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/rfcr_pkg.sv
sv/rfcr_in_if.sv
sv/rfcr_out_if.sv
sv/rfcr_front.sv
sv/rfcr_frame_queue.sv
sv/rfcr_back.sv
sv/radio_frame_checker_reassembler_unit.sv
tb/radio_frame_checker_reassembler_unit_tb.sv
